@@ rtl/tcp_retransmit_timer_table_assert.svh @@
// ----------------------------------------------------------------------------
// Retransmit timer table assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef TCP_RETRANSMIT_TIMER_TABLE_ASSERT_SVH
`define TCP_RETRANSMIT_TIMER_TABLE_ASSERT_SVH

// same-cycle implication
`define TRTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/trtt_pkg.sv @@
// ----------------------------------------------------------------------------
// Retransmit timer table package
// Field widths, action and status codes, ALU op, transfer and entry types.
// ----------------------------------------------------------------------------
package trtt_pkg;

  localparam int TIME_BITS = 48;
  localparam int ID_BITS   = 16;
  localparam int SEQ_BITS  = 32;
  localparam int DLY_BITS  = 32;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_CHECK  = 2'd3;

  localparam logic [2:0] ST_SET_OK     = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_CANCELLED  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_EXPIRED    = 3'd4;
  localparam logic [2:0] ST_CHECK_DONE = 3'd5;

  typedef enum logic [2:0] {
    ALU_ADD_SAT,
    ALU_SUB,
    ALU_GT,
    ALU_EQ,
    ALU_LE
  } alu_op_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [TIME_BITS-1:0] now_time;
    logic [DLY_BITS-1:0]  delay_ticks;
    logic [SEQ_BITS-1:0]  seq_num;
    logic                 fin_flag;
    logic [ID_BITS-1:0]   timer_id;
    logic                 measure_rtt;
  } item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ID_BITS-1:0]   out_id;
    logic [SEQ_BITS-1:0]  out_seq;
    logic [TIME_BITS-1:0] rtt_sample;
    logic                 rtt_valid;
    logic                 fin_acked;
    logic                 any_expired;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [SEQ_BITS-1:0]  seq;
    logic                 fin;
    logic [TIME_BITS-1:0] created;
    logic [TIME_BITS-1:0] deadline;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

@@ rtl/trtt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module trtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/trtt_alu.sv @@
// ----------------------------------------------------------------------------
// Retransmit timer table shared unit
// Saturating deadline add, RTT subtract and the scan compares.
// ----------------------------------------------------------------------------
module trtt_alu (
  input  trtt_pkg::alu_op_t                op,
  input  logic [trtt_pkg::TIME_BITS-1:0]   a,
  input  logic [trtt_pkg::TIME_BITS-1:0]   b,
  output logic [trtt_pkg::TIME_BITS-1:0]   value,
  output logic                             flag
);
  import trtt_pkg::*;

  logic [TIME_BITS:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    value = '0;
    flag  = 1'b0;
    case (op)
      ALU_ADD_SAT: value = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
      ALU_SUB:     value = a - b;
      ALU_GT:      flag  = (a > b);
      ALU_EQ:      flag  = (a == b);
      ALU_LE:      flag  = (a <= b);
      default:     value = '0;
    endcase
  end

endmodule

@@ rtl/tcp_retransmit_timer_table.sv @@
// ----------------------------------------------------------------------------
// Retransmit timer table
// Ordered table of TCP retransmission timers with push, insert by
// sequence, cancel by id and expiry check, run by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                    transfer
//  command   start, busy, item          start high while busy low
//  result    result_valid, result       every cycle result_valid is high
//
//  Each table entry scanned takes a RAM read and a shared compare, and each
//  entry moved on an insert or removal takes a RAM read and a RAM write.
//  A check pays a removal per expired entry, up to DEPTH removals on a full
//  table.
//  Reset is synchronous and empties the table; the id counter restarts at 1.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "tcp_retransmit_timer_table_assert.svh"

module tcp_retransmit_timer_table #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  trtt_pkg::item_t   item,
  output logic              busy,
  output logic              result_valid,
  output trtt_pkg::result_t result
);
  import trtt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DL, S_SCAN_RD, S_SCAN_CMP, S_DN_RD, S_DN_WR, S_WRITE,
    S_RTT, S_UP_RD, S_UP_WR, S_CHK, S_CHK_CMP
  } state_t;

  state_t               state;
  item_t                req;
  logic [CW-1:0]        count;
  logic [ID_BITS-1:0]   next_id;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic [TIME_BITS-1:0] deadline;
  entry_t               hold;
  logic                 any;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  entry_t               wdata;
  logic [ENTRY_BITS-1:0] rdata;
  entry_t               rd;
  logic [CW-1:0]        idx_m1;
  logic [CW-1:0]        idx_p1;

  alu_op_t              alu_op;
  logic [TIME_BITS-1:0] alu_a;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS-1:0] alu_val;
  logic                 alu_flag;

  function automatic result_t mk_result(logic [2:0] status, logic [ID_BITS-1:0] id,
                                        logic [SEQ_BITS-1:0] seq,
                                        logic [TIME_BITS-1:0] rtt, logic rv,
                                        logic fin, logic any_exp, logic fin_item);
    mk_result = '{status, id, seq, rtt, rv, fin, any_exp, fin_item};
  endfunction

  assign rd     = entry_t'(rdata);
  assign idx_m1 = idx - 1'b1;
  assign idx_p1 = idx + 1'b1;
  assign busy   = (state != S_IDLE);

  trtt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  trtt_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .value (alu_val),
    .flag  (alu_flag)
  );

  always_comb begin
    alu_op = ALU_ADD_SAT;
    alu_a  = req.now_time;
    alu_b  = TIME_BITS'(req.delay_ticks);
    case (state)
      S_SCAN_CMP: begin
        if (req.action == ACT_INSERT) begin
          alu_op = ALU_GT;
          alu_a  = TIME_BITS'(rd.seq);
          alu_b  = TIME_BITS'(req.seq_num);
        end else begin
          alu_op = ALU_EQ;
          alu_a  = TIME_BITS'(rd.id);
          alu_b  = TIME_BITS'(req.timer_id);
        end
      end
      S_RTT: begin
        alu_op = ALU_SUB;
        alu_a  = req.now_time;
        alu_b  = hold.created;
      end
      S_CHK_CMP: begin
        alu_op = ALU_LE;
        alu_a  = rd.deadline;
        alu_b  = req.now_time;
      end
      default: alu_op = ALU_ADD_SAT;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rd;
    raddr = idx[AW-1:0];
    case (state)
      S_DN_RD: raddr = idx_m1[AW-1:0];
      S_UP_RD: raddr = idx_p1[AW-1:0];
      S_CHK:   raddr = '0;
      S_DN_WR: we = 1'b1;
      S_UP_WR: we = 1'b1;
      S_WRITE: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = '{id: next_id, seq: req.seq_num, fin: req.fin_flag,
                  created: req.now_time, deadline: deadline};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      next_id      <= ID_BITS'(1);
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= item;
            idx <= '0;
            any <= 1'b0;
            if (item.action == ACT_CANCEL) begin
              state <= S_SCAN_RD;
            end else if (item.action == ACT_CHECK) begin
              state <= S_CHK;
            end else begin
              state <= S_DL;
            end
          end
        end
        S_DL: begin
          deadline <= alu_val;
          if (count == FULL) begin
            result_valid <= 1'b1;
            result       <= mk_result(ST_FULL, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
            state        <= S_IDLE;
          end else if (req.action == ACT_PUSH) begin
            pos   <= count;
            state <= S_WRITE;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx == count) begin
            if (req.action == ACT_INSERT) begin
              pos   <= count;
              state <= S_WRITE;
            end else begin
              result_valid <= 1'b1;
              result       <= mk_result(ST_NOT_FOUND, req.timer_id, '0, '0,
                                        1'b0, 1'b0, 1'b0, 1'b1);
              state        <= S_IDLE;
            end
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (alu_flag) begin
            pos <= idx;
            if (req.action == ACT_INSERT) begin
              idx   <= count;
              state <= S_DN_RD;
            end else begin
              hold  <= rd;
              state <= S_RTT;
            end
          end else begin
            idx   <= idx_p1;
            state <= S_SCAN_RD;
          end
        end
        S_DN_RD: state <= (idx == pos) ? S_WRITE : S_DN_WR;
        S_DN_WR: begin
          idx   <= idx_m1;
          state <= S_DN_RD;
        end
        S_WRITE: begin
          count        <= count + 1'b1;
          next_id      <= next_id + 1'b1;
          result_valid <= 1'b1;
          result       <= mk_result(ST_SET_OK, next_id, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
          state        <= S_IDLE;
        end
        S_RTT: begin
          result_valid <= 1'b1;
          result       <= mk_result(ST_CANCELLED, hold.id, hold.seq,
                                    req.measure_rtt ? alu_val : '0, req.measure_rtt,
                                    hold.fin, 1'b0, 1'b1);
          idx          <= pos;
          state        <= S_UP_RD;
        end
        S_UP_RD: begin
          if (idx_p1 >= count) begin
            count <= count - 1'b1;
            state <= (req.action == ACT_CHECK) ? S_CHK : S_IDLE;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          idx   <= idx_p1;
          state <= S_UP_RD;
        end
        S_CHK: begin
          if (count == '0) begin
            result_valid <= 1'b1;
            result       <= mk_result(ST_CHECK_DONE, '0, '0, '0, 1'b0, 1'b0, any, 1'b1);
            state        <= S_IDLE;
          end else begin
            state <= S_CHK_CMP;
          end
        end
        S_CHK_CMP: begin
          result_valid <= 1'b1;
          if (alu_flag) begin
            result <= mk_result(ST_EXPIRED, rd.id, rd.seq, '0, 1'b0, 1'b0, 1'b0, 1'b0);
            any    <= 1'b1;
            idx    <= '0;
            state  <= S_UP_RD;
          end else begin
            result <= mk_result(ST_CHECK_DONE, '0, '0, '0, 1'b0, 1'b0, any, 1'b1);
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TRTT_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL, "entry count above depth")
  `TRTT_ASSERT_NOW(a_full_status, result_valid && result.status == ST_FULL,
    count == FULL, "full reported with free slots")
  `TRTT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command not busy")
  `TRTT_ASSERT_NOW(a_result_busy, result_valid, $past(busy),
    "result without a command in progress")

endmodule

@@ tb/tcp_retransmit_timer_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Retransmit timer table testbench
// Drives push, insert, cancel and check commands with random gaps. A scoreboard
// keeps its own ordered timer table and checks each result strobe in order.
// ----------------------------------------------------------------------------
import trtt_pkg::*;

class timer_scoreboard;
  localparam int DEPTH = 16;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  entry_t           table_q[$];
  logic [ID_BITS-1:0] next_id;
  result_t          pending_q[$];
  int               mismatches;

  function void clear();
    table_q.delete();
    pending_q.delete();
    next_id = 1;
  endfunction

  function void note_item(item_t it);
    result_t r;
    entry_t e;
    logic [TIME_BITS:0] sum;
    int pos;
    int k;
    r = '0;
    r.last = 1'b1;
    if (it.action == ACT_PUSH || it.action == ACT_INSERT) begin
      if (table_q.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        sum = {1'b0, it.now_time} + (TIME_BITS + 1)'(it.delay_ticks);
        e.id = next_id;
        e.seq = it.seq_num;
        e.fin = it.fin_flag;
        e.created = it.now_time;
        e.deadline = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
        pos = table_q.size();
        if (it.action == ACT_INSERT) begin
          for (int i = 0; i < table_q.size(); i++) begin
            if (table_q[i].seq > it.seq_num) begin
              pos = i;
              break;
            end
          end
        end
        table_q.insert(pos, e);
        r.status = ST_SET_OK;
        r.out_id = next_id;
        next_id++;
      end
      pending_q.push_back(r);
    end else if (it.action == ACT_CANCEL) begin
      r.status = ST_NOT_FOUND;
      r.out_id = it.timer_id;
      for (int i = 0; i < table_q.size(); i++) begin
        if (table_q[i].id == it.timer_id) begin
          r.status = ST_CANCELLED;
          r.out_seq = table_q[i].seq;
          r.rtt_valid = it.measure_rtt;
          r.rtt_sample = it.measure_rtt ? it.now_time - table_q[i].created : '0;
          r.fin_acked = table_q[i].fin;
          table_q.delete(i);
          break;
        end
      end
      pending_q.push_back(r);
    end else begin
      k = 0;
      while (table_q.size() > 0 && table_q[0].deadline <= it.now_time) begin
        r = '0;
        r.status = ST_EXPIRED;
        r.out_id = table_q[0].id;
        r.out_seq = table_q[0].seq;
        pending_q.push_back(r);
        void'(table_q.pop_front());
        k++;
      end
      r = '0;
      r.status = ST_CHECK_DONE;
      r.any_expired = (k > 0);
      r.last = 1'b1;
      pending_q.push_back(r);
    end
  endfunction

  function void check_result(result_t got);
    result_t exp_r;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("result mismatch: status %0d/%0d id %h/%h seq %h/%h rtt %h/%h",
               exp_r.status, got.status, exp_r.out_id, got.out_id,
               exp_r.out_seq, got.out_seq, exp_r.rtt_sample, got.rtt_sample);
        $display(" rv %b/%b fin %b/%b any %b/%b last %b/%b",
                 exp_r.rtt_valid, got.rtt_valid, exp_r.fin_acked, got.fin_acked,
                 exp_r.any_expired, got.any_expired, exp_r.last, got.last);
      end
    end
  endfunction
endclass

module tcp_retransmit_timer_table_tb;
  localparam int CYCLE_LIMIT = 400000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  timer_scoreboard sb;
  logic [TIME_BITS-1:0] clock_now;
  logic [ID_BITS-1:0]   issued_id;
  int cycles;

  always #4 clk = ~clk;

  tcp_retransmit_timer_table u_top (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) sb.check_result(result);
    if (!rst && start && !busy) sb.note_item(item);
    if (cycles > CYCLE_LIMIT) begin
      $display("tcp_retransmit_timer_table_tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
    item <= '0;
  endtask

  task automatic send_op(logic [1:0] act, logic [TIME_BITS-1:0] now_t,
                         logic [31:0] dly, logic [31:0] seq, logic fin,
                         logic [ID_BITS-1:0] tid, logic meas);
    item_t it;
    it.action = act;
    it.now_time = now_t;
    it.delay_ticks = dly;
    it.seq_num = seq;
    it.fin_flag = fin;
    it.timer_id = tid;
    it.measure_rtt = meas;
    send_item(it);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    logic [1:0] act;
    logic [ID_BITS-1:0] tid;
    int r;
    r = $urandom_range(0, 99);
    act = (r < 35) ? ACT_PUSH : (r < 60) ? ACT_INSERT : (r < 82) ? ACT_CANCEL : ACT_CHECK;
    clock_now = clock_now + TIME_BITS'($urandom_range(0, 400));
    if ($urandom_range(0, 19) == 0) clock_now = TIME_BITS'({$urandom, $urandom});
    if (sb.table_q.size() > 0 && $urandom_range(0, 3) != 0)
      tid = sb.table_q[$urandom_range(0, sb.table_q.size() - 1)].id;
    else
      tid = ID_BITS'($urandom);
    send_op(act, clock_now,
            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1500),
            ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40),
            1'($urandom), tid, 1'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.mismatches = 0;
    cycles = 0;
    clock_now = 100;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, insert order, full, cancel hit/miss, expiry
    send_op(ACT_CHECK, '0, '0, '0, 1'b0, '0, 1'b0);
    send_op(ACT_PUSH, 48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, 1'b0);
    send_op(ACT_PUSH, 48'd10, 32'd0, 32'd0, 1'b0, '0, 1'b0);
    send_op(ACT_INSERT, 48'd20, 32'd5, 32'd5, 1'b1, '0, 1'b0);
    send_op(ACT_INSERT, 48'd20, 32'd5, 32'd5, 1'b0, '0, 1'b0);
    send_op(ACT_CANCEL, 48'd5, '0, '0, 1'b0, 16'd3, 1'b1);
    send_op(ACT_CANCEL, 48'd50, '0, '0, 1'b0, 16'd1, 1'b1);
    send_op(ACT_CANCEL, 48'd50, '0, '0, 1'b0, 16'd4, 1'b0);
    send_op(ACT_CANCEL, 48'd50, '0, '0, 1'b0, 16'hFFFF, 1'b1);
    for (int i = 0; i < 16; i++)
      send_op(i[0] ? ACT_INSERT : ACT_PUSH, 48'd100, 32'(i * 7), $urandom, i[1], '0, 1'b0);
    send_op(ACT_PUSH, 48'd100, 32'd1, 32'd1, 1'b0, '0, 1'b0);
    send_op(ACT_CHECK, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, '0, 1'b0);
    drain();

    for (int n = 0; n < 230; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) random_item();
      if (n > 115 && n < 128) drain();
      else if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    drain();
    repeat (80) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("tcp_retransmit_timer_table_tb OK");
    else
      $display("tcp_retransmit_timer_table_tb NOT OK");
    $finish;
  end
endmodule
